@@ design/tpwm_pkg.sv @@
// Shared types, codes and sizing constants of the timed PWM tone burst generator.
`timescale 1ns / 1ps
`default_nettype none
package tpwm_pkg;

	localparam int TICK_HZ     = 1000000;
	localparam int FREQ_W      = 16;
	localparam int VOL_W       = 7;
	localparam int DUR_W       = 31;
	localparam int TIME_W      = 32;
	localparam int GUARD_W     = 10;
	localparam int CFG_W       = 16;
	localparam int PER_W       = 17;
	localparam int PER_MIN     = 2;
	localparam int PER_MAX     = 65536;
	localparam int VOL_MAX     = 100;
	localparam int PULSE_BIAS  = 199;
	localparam int PULSE_DEN   = 200;
	localparam int NUM_PER_W   = $clog2(TICK_HZ + (2 ** (FREQ_W - 1)) + 1);
	localparam int NUM_PUL_W   = $clog2(PER_MAX * VOL_MAX + PULSE_BIAS + 1);
	localparam int DIV_W       = NUM_PER_W;
	localparam int DEN_W       = FREQ_W;
	localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

	// Dividing the pulse numerator by 200 is a shift by three followed by a
	// multiplication with the rounded-up reciprocal of 25, which is exact for
	// every numerator below 2**23.
	localparam int PUL_PRE_SH   = 3;
	localparam int PUL_RECIP_W  = NUM_PUL_W - PUL_PRE_SH;
	localparam int PUL_RECIP    = 671089;
	localparam int PUL_RECIP_SH = 24;
	localparam int PUL_PROD_W   = 2 * PUL_RECIP_W;
	localparam int PUL_QUOT_W   = PUL_PROD_W - PUL_RECIP_SH;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	localparam logic [1:0] REG_ENABLED  = 2'd0;
	localparam logic [1:0] REG_MIN_FREQ = 2'd1;
	localparam logic [1:0] REG_GUARD    = 2'd2;

	typedef enum logic [1:0] {
		CLS_TICK,
		CLS_START,
		CLS_STOP,
		CLS_REPORT
	} cls_t;

	typedef struct packed {
		cls_t               cls;
		logic [FREQ_W-1:0]  freq;
		logic [VOL_W-1:0]   vol;
		logic [DUR_W-1:0]   dur;
	} item_t;

	typedef struct packed {
		logic accepted;
		logic tone_out;
		logic running;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV_PER,
		BK_PULSE
	} back_state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quot;
	} div_rsp_t;

endpackage
`default_nettype wire

@@ design/tpwm_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tpwm_div import tpwm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DIV_W-1:0]     num_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DEN_W:0]       shifted;
	logic                 fits;

	assign shifted = {rem_q, num_q[DIV_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], fits};
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : shifted[DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule
`default_nettype wire

@@ design/tpwm_front.sv @@
// Front end: configuration registers, item classification and the item queue.
`timescale 1ns / 1ps
`default_nettype none
module tpwm_front import tpwm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         kind,
	input  wire logic [FREQ_W-1:0]  tone_freq,
	input  wire logic [7:0]         volume,
	input  wire logic [DUR_W-1:0]   tone_len,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data,
	output logic [GUARD_W-1:0]      stop_guard,
	output logic                    head_valid,
	output item_t                   head,
	input  wire logic               head_pop
);

	logic                enabled_q;
	logic [FREQ_W-1:0]   min_freq_q;
	logic [GUARD_W-1:0]  guard_q;
	item_t               mem_q [2];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          cnt_q;
	item_t               in_item;
	logic [FREQ_W-1:0]   fmin;
	logic                do_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b1;
			min_freq_q <= FREQ_W'(100);
			guard_q    <= GUARD_W'(20);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLED:  enabled_q  <= cfg_data[0];
				REG_MIN_FREQ: min_freq_q <= cfg_data[FREQ_W-1:0];
				REG_GUARD:    guard_q    <= cfg_data[GUARD_W-1:0];
				default: ;
			endcase
		end
	end

	assign stop_guard = guard_q;
	assign fmin       = (min_freq_q == '0) ? FREQ_W'(1) : min_freq_q;

	always_comb begin
		in_item.freq = (tone_freq < fmin) ? fmin : tone_freq;
		in_item.vol  = (volume > 8'(VOL_MAX)) ? VOL_W'(VOL_MAX) : volume[VOL_W-1:0];
		in_item.dur  = tone_len;
		case (kind)
			KIND_TICK:  in_item.cls = CLS_TICK;
			KIND_START: in_item.cls = (enabled_q && volume != '0) ? CLS_START : CLS_REPORT;
			KIND_STOP:  in_item.cls = CLS_STOP;
			default:    in_item.cls = CLS_REPORT;
		endcase
	end

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head       = mem_q[rd_q];
	assign do_push    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (head_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, head_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= in_item;
	end

endmodule
`default_nettype wire

@@ design/tpwm_back.sv @@
// Back end: tone state, start computation over the divider and the result queue.
`timescale 1ns / 1ps
`default_nettype none
module tpwm_back import tpwm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [GUARD_W-1:0] stop_guard,
	input  wire logic               head_valid,
	input  wire item_t              head,
	output logic                    head_pop,
	output div_req_t                div_req,
	input  wire div_rsp_t           div_rsp,
	output logic                    empty,
	input  wire logic               pop,
	output res_t                    res
);

	back_state_t         state_q;
	back_state_t         state_next;
	logic [TIME_W-1:0]   time_now_q;
	logic [TIME_W-1:0]   stop_due_q;
	logic [PER_W-1:0]    period_q;
	logic [PER_W-1:0]    pulse_q;
	logic [PER_W-1:0]    pwm_q;
	logic                run_q;
	logic [PER_W-1:0]    per_new_q;
	logic [NUM_PUL_W-1:0] pul_num_q;
	res_t                oq_q [2];
	logic                oq_wr_q;
	logic                oq_rd_q;
	logic [1:0]          oq_cnt_q;
	logic                oq_full;
	logic                oq_pop;
	logic                do_simple;
	logic                start_per;
	logic                start_pul;
	logic                commit;
	logic [TIME_W-1:0]   n_now;
	logic [TIME_W-1:0]   n_diff;
	logic [PER_W-1:0]    n_pwm;
	logic [PER_W-1:0]    n_pulse;
	logic                n_run;
	logic [PER_W-1:0]    per_clamp;
	logic [NUM_PUL_W-1:0] pul_num;
	logic [PUL_PROD_W-1:0] pul_prod;
	logic [PUL_QUOT_W-1:0] pul_quot;
	logic [PER_W-1:0]    pul_clamp;
	logic [TIME_W-1:0]   due_raw;
	logic [TIME_W-1:0]   guard_time;
	logic [TIME_W-1:0]   due_diff;
	res_t                push_res;

	assign oq_full = oq_cnt_q == 2'd2;
	assign empty   = oq_cnt_q == 2'd0;
	assign oq_pop  = pop && !empty;
	assign res     = oq_q[oq_rd_q];

	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE:    if (head_valid && !oq_full && head.cls == CLS_START) state_next = BK_DIV_PER;
			BK_DIV_PER: if (div_rsp.done) state_next = BK_PULSE;
			BK_PULSE:   state_next = BK_IDLE;
			default:    state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		do_simple = 1'b0;
		start_per = 1'b0;
		start_pul = 1'b0;
		commit    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (head_valid && !oq_full) begin
					start_per = head.cls == CLS_START;
					do_simple = head.cls != CLS_START;
				end
			end
			BK_DIV_PER: start_pul = div_rsp.done;
			BK_PULSE:   commit    = 1'b1;
			default: ;
		endcase
	end

	assign head_pop = do_simple || commit;

	// Outcome of a tick, stop or report item.
	always_comb begin
		n_now   = time_now_q;
		n_pwm   = pwm_q;
		n_pulse = pulse_q;
		n_run   = run_q;
		n_diff  = '0;
		case (head.cls)
			CLS_TICK: begin
				n_now  = time_now_q + 1'b1;
				n_diff = n_now - stop_due_q;
				if (run_q) begin
					n_pwm = pwm_q + 1'b1;
					if (n_pwm >= period_q) n_pwm = '0;
					if (!n_diff[TIME_W-1]) begin
						n_run   = 1'b0;
						n_pwm   = '0;
						n_pulse = '0;
					end
				end
			end
			CLS_STOP: begin
				n_run   = 1'b0;
				n_pwm   = '0;
				n_pulse = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (div_rsp.quot < DIV_W'(PER_MIN)) begin
			per_clamp = PER_W'(PER_MIN);
		end else if (div_rsp.quot > DIV_W'(PER_MAX)) begin
			per_clamp = PER_W'(PER_MAX);
		end else begin
			per_clamp = div_rsp.quot[PER_W-1:0];
		end
		pul_num  = NUM_PUL_W'(per_clamp) * NUM_PUL_W'(head.vol) + NUM_PUL_W'(PULSE_BIAS);
		pul_prod = PUL_PROD_W'(pul_num_q[NUM_PUL_W-1:PUL_PRE_SH]) * PUL_PROD_W'(PUL_RECIP);
		pul_quot = pul_prod[PUL_PROD_W-1:PUL_RECIP_SH];
		if (pul_quot == '0) begin
			pul_clamp = PER_W'(1);
		end else if (PER_W'(pul_quot) >= per_new_q) begin
			pul_clamp = per_new_q - 1'b1;
		end else begin
			pul_clamp = PER_W'(pul_quot);
		end
		due_raw    = time_now_q + {1'b0, head.dur};
		guard_time = time_now_q + TIME_W'(stop_guard);
		due_diff   = guard_time - due_raw;
	end

	always_comb begin
		div_req.start = start_per;
		div_req.num   = DIV_W'(TICK_HZ) + DIV_W'(head.freq >> 1);
		div_req.den   = head.freq;
	end

	always_comb begin
		if (commit) begin
			push_res = '{accepted: 1'b1, tone_out: 1'b1, running: 1'b1};
		end else begin
			push_res = '{accepted: 1'b0, tone_out: n_run && (n_pwm < n_pulse), running: n_run};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			time_now_q <= '0;
			stop_due_q <= '0;
			period_q   <= '0;
			pulse_q    <= '0;
			pwm_q      <= '0;
			run_q      <= 1'b0;
			oq_wr_q    <= 1'b0;
			oq_rd_q    <= 1'b0;
			oq_cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (do_simple) begin
				time_now_q <= n_now;
				pwm_q      <= n_pwm;
				pulse_q    <= n_pulse;
				run_q      <= n_run;
			end else if (commit) begin
				period_q   <= per_new_q;
				pulse_q    <= pul_clamp;
				pwm_q      <= '0;
				run_q      <= 1'b1;
				stop_due_q <= due_diff[TIME_W-1] ? due_raw : guard_time;
			end
			if (head_pop) oq_wr_q <= ~oq_wr_q;
			if (oq_pop) oq_rd_q <= ~oq_rd_q;
			oq_cnt_q <= oq_cnt_q + {1'b0, head_pop} - {1'b0, oq_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (start_pul) begin
			per_new_q <= per_clamp;
			pul_num_q <= pul_num;
		end
		if (head_pop) oq_q[oq_wr_q] <= push_res;
	end

endmodule
`default_nettype wire

@@ design/timed_pwm_tone_burst.sv @@
// Top level of the timed PWM tone burst generator.
`timescale 1ns / 1ps
`default_nettype none
// Items enter through a two-entry queue and results leave through another, so
// each side may stall on its own. Tick, stop and unused items and rejected starts
// pass through the back end without the divider, so a steady stream of ticks runs
// at one item per clock while the result queue has room. An accepted start item
// occupies the back end while it loads the one-bit-per-cycle divider, runs 20
// divider steps for the tone period, clamps the period and forms the pulse width
// by a multiplication with a reciprocal. Every item yields exactly one result.
module timed_pwm_tone_burst import tpwm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         kind,
	input  wire logic [FREQ_W-1:0]  tone_freq,
	input  wire logic [7:0]         volume,
	input  wire logic [DUR_W-1:0]   tone_len,
	output logic                    empty,
	input  wire logic               pop,
	output logic                    accepted,
	output logic                    tone_out,
	output logic                    running,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [CFG_W-1:0]   cfg_data
);

	logic [GUARD_W-1:0] stop_guard;
	logic               head_valid;
	item_t              head;
	logic               head_pop;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	res_t               res;

	tpwm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.tone_freq    (tone_freq),
		.volume       (volume),
		.tone_len     (tone_len),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.stop_guard   (stop_guard),
		.head_valid   (head_valid),
		.head         (head),
		.head_pop     (head_pop)
	);

	tpwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tpwm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.stop_guard (stop_guard),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

	assign accepted = res.accepted;
	assign tone_out = res.tone_out;
	assign running  = res.running;

endmodule
`default_nettype wire
